### src/multichannel_adsr_wave_synth_assert.svh
// Assertion macros used by the synthesizer RTL (mas_back).
// Expects signals named clk and rst in the scope of each use.
`ifndef MULTICHANNEL_ADSR_WAVE_SYNTH_ASSERT_SVH
`define MULTICHANNEL_ADSR_WAVE_SYNTH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/mas_pkg.sv
// Shared types, codes and constants of the ADSR wavetable synthesizer.
// Holds the quarter-wave sine table, built at elaboration. No dependencies.
package mas_pkg;

  localparam int VOICES       = 8;
  localparam int VOICE_W      = 3;
  localparam int PHASE_BITS   = 16;
  localparam int TIME_BITS    = 20;
  localparam int SINE_ENTRIES = 256;

  localparam logic [16:0] FULL       = 17'd32768;
  localparam logic [15:0] DUTY_LO    = 16'd3277;
  localparam logic [15:0] DUTY_HI    = 16'd62259;
  localparam logic [15:0] NOISE_SEED = 16'hACE1;
  localparam logic [3:0]  VOICES_RST = 4'd4;

  localparam logic [2:0] MODE_TICK = 3'd0;
  localparam logic [2:0] MODE_PLAY = 3'd1;
  localparam logic [2:0] MODE_ENV  = 3'd2;
  localparam logic [2:0] MODE_STOP = 3'd3;
  localparam logic [2:0] MODE_ALL  = 3'd4;

  localparam logic [2:0] WAVE_SQUARE = 3'd0;
  localparam logic [2:0] WAVE_TRI    = 3'd1;
  localparam logic [2:0] WAVE_SAW    = 3'd2;
  localparam logic [2:0] WAVE_NOISE  = 3'd3;
  localparam logic [2:0] WAVE_PULSE  = 3'd4;
  localparam logic [2:0] WAVE_SINE   = 3'd5;

  localparam logic [2:0] ENV_OFF     = 3'd0;
  localparam logic [2:0] ENV_ATTACK  = 3'd1;
  localparam logic [2:0] ENV_DECAY   = 3'd2;
  localparam logic [2:0] ENV_SUSTAIN = 3'd3;
  localparam logic [2:0] ENV_RELEASE = 3'd4;

  localparam logic [1:0] REG_VOICES = 2'd0;

  typedef enum logic [2:0] {
    K_TICK, K_PLAY, K_ENV, K_STOP, K_ALL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [VOICE_W-1:0]    voice;
    logic [15:0]           step;
    logic [15:0]           vol;
    logic [2:0]            wave;
    logic [15:0]           duty;
    logic [TIME_BITS-1:0]  att;
    logic [TIME_BITS-1:0]  dec;
    logic [15:0]           sus;
    logic [TIME_BITS-1:0]  rel;
  } item_t;

  typedef logic [15:0] sine_tab_t [SINE_ENTRIES+1];

  // Degree-9 Taylor polynomial in Q30, rounded to Q15.
  function automatic sine_tab_t build_sine();
    sine_tab_t tb;
    logic [63:0] x, x2, t, s, v;
    for (int k = 0; k <= SINE_ENTRIES; k++) begin
      x  = (64'd1686629713 * 64'(k)) / SINE_ENTRIES;
      x2 = (x * x) >> 30;
      t  = 64'd1073741824 - x2 / 72;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      v  = (s * 64'd32768 + 64'd536870912) >> 30;
      if (v > 64'd32768) v = 64'd32768;
      tb[k] = v[15:0];
    end
    return tb;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

### src/mas_front.sv
// Input side: takes items, decodes the mode, clamps levels and duty,
// and holds them in a two-entry queue. Depends on mas_pkg.
module mas_front import mas_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           mode,
  input  logic [VOICE_W-1:0]   voice,
  input  logic [15:0]          phase_step,
  input  logic [15:0]          volume,
  input  logic [2:0]           waveform,
  input  logic [15:0]          duty,
  input  logic [TIME_BITS-1:0] attack_len,
  input  logic [TIME_BITS-1:0] decay_len,
  input  logic [15:0]          sustain_level,
  input  logic [TIME_BITS-1:0] release_len,
  output logic                 q_valid,
  output item_t                q_item,
  input  logic                 q_ready
);

  item_t       qmem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  item_t       cls;
  logic        known;
  logic        do_wr, do_rd;

  always_comb begin
    cls       = '0;
    known     = 1'b1;
    unique case (mode)
      MODE_TICK: cls.kind = K_TICK;
      MODE_PLAY: cls.kind = K_PLAY;
      MODE_ENV:  cls.kind = K_ENV;
      MODE_STOP: cls.kind = K_STOP;
      MODE_ALL:  cls.kind = K_ALL;
      default: begin
        cls.kind = K_TICK;
        known    = 1'b0;
      end
    endcase
    cls.voice = voice;
    cls.step  = phase_step;
    cls.vol   = ({1'b0, volume} > FULL) ? FULL[15:0] : volume;
    cls.wave  = waveform;
    cls.duty  = (duty < DUTY_LO) ? DUTY_LO : ((duty > DUTY_HI) ? DUTY_HI : duty);
    cls.att   = attack_len;
    cls.dec   = decay_len;
    cls.sus   = ({1'b0, sustain_level} > FULL) ? FULL[15:0] : sustain_level;
    cls.rel   = release_len;
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = qmem[rd_ptr];
  // unknown modes are taken and dropped here
  assign do_wr   = push && !full && known;
  assign do_rd   = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        qmem[wr_ptr] <= cls;
        wr_ptr       <= !wr_ptr;
      end
      if (do_rd) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

### src/mas_back.sv
// Execution side: voice state, command handling and the per-tick walk over
// voices (envelope divide, waveform, products, mix divide, scale). Uses mas_pkg.
module mas_back import mas_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [3:0]  voices_en,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_ready,
  output logic        res_valid,
  output logic [15:0] res_audio,
  output logic [7:0]  res_active,
  input  logic        res_ready
);

  `include "multichannel_adsr_wave_synth_assert.svh"

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_VOICE = 9'b000000010,
    ST_DIV   = 9'b000000100,
    ST_ENVW  = 9'b000001000,
    ST_MUL1  = 9'b000010000,
    ST_MUL2  = 9'b000100000,
    ST_CDIV  = 9'b001000000,
    ST_SCALE = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  state_t st;

  logic [15:0]          phase_acc     [VOICES];
  logic [15:0]          step_store    [VOICES];
  logic [15:0]          volume_store  [VOICES];
  logic [2:0]           wave_select   [VOICES];
  logic [15:0]          duty_store    [VOICES];
  logic [TIME_BITS-1:0] attack_store  [VOICES];
  logic [TIME_BITS-1:0] decay_store   [VOICES];
  logic [15:0]          sustain_store [VOICES];
  logic [TIME_BITS-1:0] release_store [VOICES];
  logic [2:0]           eg_state      [VOICES];
  logic [TIME_BITS-1:0] env_elapsed   [VOICES];
  logic [15:0]          eg_level      [VOICES];
  logic [15:0]          noise_reg     [VOICES];
  logic [VOICES-1:0]    voice_on;

  logic [3:0]           vidx;
  logic [3:0]           vcnt;
  logic [3:0]           n_cl;
  logic [VOICE_W-1:0]   cur;
  logic [TIME_BITS-1:0] e_inc;
  logic [35:0]          num;
  logic [TIME_BITS-1:0] den;
  logic [TIME_BITS-1:0] rem;
  logic [15:0]          quo;
  logic [4:0]           dcnt;
  logic [15:0]          env_use;
  logic [30:0]          ve;
  logic                 smp_neg;
  logic [15:0]          smp_mag;
  logic signed [49:0]   acc;
  logic [48:0]          qm;
  logic [3:0]           cden;
  logic [3:0]           crem;
  logic [5:0]           ccnt;
  logic                 mix_neg;
  logic [15:0]          audio;

  logic [16:0]          mul_a;
  logic [TIME_BITS-1:0] mul_b;
  logic [36:0]          mul_p;
  logic signed [17:0]   smp;
  logic [15:0]          noise_nx;
  logic [16:0]          tri_r;
  logic [7:0]           sidx;
  logic [15:0]          sine_m;
  logic [TIME_BITS:0]   dtry;
  logic [4:0]           ctry;
  logic [46:0]          prod;
  logic [45:0]          mq;
  logic [47:0]          m3;
  logic [17:0]          x10;
  logic [37:0]          y10;
  logic                 cmd_ok;

  assign n_cl   = (voices_en == 4'd0) ? 4'd1 :
                  ((voices_en > 4'(VOICES)) ? 4'(VOICES) : voices_en);
  assign cur    = (st == ST_IDLE) ? q_item.voice : vidx[VOICE_W-1:0];
  assign cmd_ok = ({1'b0, q_item.voice} < n_cl);
  assign e_inc  = env_elapsed[cur] + 1'b1;

  // numerator multiplier for decay and release; attack is a shift
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (eg_state[cur])
      ENV_DECAY: begin
        mul_a = FULL - {1'b0, sustain_store[cur]};
        mul_b = e_inc;
      end
      default: begin
        mul_a = {1'b0, sustain_store[cur]};
        mul_b = release_store[cur] - e_inc;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // waveform sample at the current phase
  always_comb begin
    noise_nx = {noise_reg[cur][0] ^ noise_reg[cur][2] ^ noise_reg[cur][3] ^
                noise_reg[cur][5], noise_reg[cur][15:1]};
    tri_r    = {phase_acc[cur], 1'b0};
    sidx     = phase_acc[cur][13:6];
    sine_m   = phase_acc[cur][14] ? SINE_TAB[9'(SINE_ENTRIES) - {1'b0, sidx}]
                                  : SINE_TAB[sidx];
    case (wave_select[cur])
      WAVE_SQUARE: smp = phase_acc[cur][15] ? -18'sd32768 : 18'sd32768;
      WAVE_TRI:    smp = phase_acc[cur][15] ? 18'sd98304 - $signed({1'b0, tri_r})
                                            : $signed({1'b0, tri_r}) - 18'sd32768;
      WAVE_SAW:    smp = $signed({2'b0, phase_acc[cur]}) - 18'sd32768;
      WAVE_NOISE:  smp = $signed({2'b0, noise_nx}) - 18'sd32768;
      WAVE_PULSE:  smp = (phase_acc[cur] < duty_store[cur]) ? 18'sd32768 : -18'sd32768;
      WAVE_SINE:   smp = phase_acc[cur][15] ? -$signed({2'b0, sine_m})
                                            : $signed({2'b0, sine_m});
      default:     smp = '0;
    endcase
  end

  assign dtry = {rem, num[35]};
  assign ctry = {crem, qm[48]};
  assign prod = 47'(ve * smp_mag);
  assign mq   = (qm > 49'h2000_0000_0000) ? 46'h2000_0000_0000 : qm[45:0];
  assign m3   = {1'b0, mq, 1'b0} + {2'b0, mq};
  assign x10  = m3[47:30];
  // floor(x/10) by reciprocal; exact for x below 2^22
  assign y10  = x10 * 20'd838861;

  assign q_ready    = (st == ST_IDLE);
  assign res_valid  = (st == ST_DONE);
  assign res_audio  = audio;
  assign res_active = 8'(voice_on);

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      voice_on <= '0;
      vidx     <= '0;
      for (int i = 0; i < VOICES; i++) begin
        phase_acc[i]     <= '0;
        step_store[i]    <= '0;
        volume_store[i]  <= '0;
        wave_select[i]   <= '0;
        duty_store[i]    <= 16'h8000;
        attack_store[i]  <= '0;
        decay_store[i]   <= '0;
        sustain_store[i] <= '0;
        release_store[i] <= '0;
        eg_state[i]      <= ENV_OFF;
        env_elapsed[i]   <= '0;
        eg_level[i]      <= '0;
        noise_reg[i]     <= NOISE_SEED;
      end
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_item.kind)
              K_TICK: begin
                vidx <= '0;
                vcnt <= '0;
                acc  <= '0;
                st   <= ST_VOICE;
              end
              K_PLAY: if (cmd_ok) begin
                step_store[cur]   <= q_item.step;
                volume_store[cur] <= q_item.vol;
                wave_select[cur]  <= q_item.wave;
                duty_store[cur]   <= q_item.duty;
                phase_acc[cur]    <= '0;
                env_elapsed[cur]  <= '0;
                eg_level[cur]     <= '0;
                eg_state[cur]     <= (attack_store[cur] != '0) ? ENV_ATTACK : ENV_SUSTAIN;
                voice_on[cur]     <= 1'b1;
              end
              K_ENV: if (cmd_ok) begin
                attack_store[cur]  <= q_item.att;
                decay_store[cur]   <= q_item.dec;
                sustain_store[cur] <= q_item.sus;
                release_store[cur] <= q_item.rel;
              end
              K_STOP: if (cmd_ok) begin
                if (voice_on[cur] && release_store[cur] != '0) begin
                  eg_state[cur]    <= ENV_RELEASE;
                  env_elapsed[cur] <= '0;
                end else begin
                  voice_on[cur] <= 1'b0;
                end
              end
              K_ALL: voice_on <= '0;
              default: ;
            endcase
          end
        end

        ST_VOICE: begin
          if (vidx >= n_cl) begin
            qm      <= acc[49] ? 49'(-acc) : 49'(acc);
            mix_neg <= acc[49];
            cden    <= (vcnt == '0) ? 4'd1 : vcnt;
            crem    <= '0;
            ccnt    <= '0;
            st      <= ST_CDIV;
          end else if (!voice_on[cur]) begin
            vidx <= vidx + 1'b1;
          end else begin
            unique case (eg_state[cur])
              ENV_OFF: begin
                env_use <= '0;
                st      <= ST_MUL1;
              end
              ENV_ATTACK: begin
                if (attack_store[cur] == '0 || e_inc >= attack_store[cur]) begin
                  eg_level[cur]    <= FULL[15:0];
                  env_use          <= FULL[15:0];
                  eg_state[cur]    <= ENV_DECAY;
                  env_elapsed[cur] <= '0;
                  st               <= ST_MUL1;
                end else begin
                  env_elapsed[cur] <= e_inc;
                  num  <= 36'({e_inc, 15'd0});
                  den  <= attack_store[cur];
                  rem  <= '0;
                  dcnt <= '0;
                  st   <= ST_DIV;
                end
              end
              ENV_DECAY: begin
                if (decay_store[cur] == '0 || e_inc >= decay_store[cur]) begin
                  eg_level[cur]    <= sustain_store[cur];
                  env_use          <= sustain_store[cur];
                  eg_state[cur]    <= ENV_SUSTAIN;
                  env_elapsed[cur] <= '0;
                  st               <= ST_MUL1;
                end else begin
                  env_elapsed[cur] <= e_inc;
                  num  <= mul_p[35:0];
                  den  <= decay_store[cur];
                  rem  <= '0;
                  dcnt <= '0;
                  st   <= ST_DIV;
                end
              end
              ENV_SUSTAIN: begin
                eg_level[cur] <= sustain_store[cur];
                env_use       <= sustain_store[cur];
                st            <= ST_MUL1;
              end
              ENV_RELEASE: begin
                if (release_store[cur] == '0 || e_inc >= release_store[cur]) begin
                  eg_level[cur]    <= '0;
                  env_use          <= '0;
                  voice_on[cur]    <= 1'b0;
                  eg_state[cur]    <= ENV_OFF;
                  env_elapsed[cur] <= '0;
                  st               <= ST_MUL1;
                end else begin
                  env_elapsed[cur] <= e_inc;
                  num  <= mul_p[35:0];
                  den  <= release_store[cur];
                  rem  <= '0;
                  dcnt <= '0;
                  st   <= ST_DIV;
                end
              end
              default: begin
                env_use <= eg_level[cur];
                st      <= ST_MUL1;
              end
            endcase
          end
        end

        // quotient is known to fit 16 bits, so the top 20 bits seed the
        // remainder; 16 restoring steps follow
        ST_DIV: begin
          if (dcnt == '0) begin
            rem <= num[35:16];
            num <= {num[15:0], 20'd0};
            quo <= '0;
          end else begin
            if (dtry >= {1'b0, den}) begin
              rem <= TIME_BITS'(dtry - {1'b0, den});
              quo <= {quo[14:0], 1'b1};
            end else begin
              rem <= dtry[TIME_BITS-1:0];
              quo <= {quo[14:0], 1'b0};
            end
            num <= {num[34:0], 1'b0};
            if (dcnt == 5'd16) st <= ST_ENVW;
          end
          dcnt <= dcnt + 1'b1;
        end

        ST_ENVW: begin
          if (eg_state[cur] == ENV_DECAY) begin
            eg_level[cur] <= 16'(FULL - {1'b0, quo});
            env_use       <= 16'(FULL - {1'b0, quo});
          end else begin
            eg_level[cur] <= quo;
            env_use       <= quo;
          end
          st <= ST_MUL1;
        end

        ST_MUL1: begin
          ve      <= 31'(volume_store[cur] * env_use);
          smp_neg <= smp[17];
          smp_mag <= smp[17] ? 16'(-smp) : smp[15:0];
          if (wave_select[cur] == WAVE_NOISE) noise_reg[cur] <= noise_nx;
          phase_acc[cur] <= phase_acc[cur] + step_store[cur];
          st <= ST_MUL2;
        end

        ST_MUL2: begin
          acc  <= smp_neg ? acc - $signed({3'b0, prod}) : acc + $signed({3'b0, prod});
          vcnt <= vcnt + 1'b1;
          vidx <= vidx + 1'b1;
          st   <= ST_VOICE;
        end

        ST_CDIV: begin
          if (ctry >= {1'b0, cden}) begin
            crem <= 4'(ctry - {1'b0, cden});
            qm   <= {qm[47:0], 1'b1};
          end else begin
            crem <= ctry[3:0];
            qm   <= {qm[47:0], 1'b0};
          end
          ccnt <= ccnt + 1'b1;
          if (ccnt == 6'd48) st <= ST_SCALE;
        end

        ST_SCALE: begin
          audio <= mix_neg ? 16'(-{1'b0, y10[37:23]}) : {1'b0, y10[37:23]};
          st    <= ST_DONE;
        end

        ST_DONE: if (res_ready) st <= ST_IDLE;

        default: st <= ST_IDLE;
      endcase
    end
  end

  `MAS_ASSERT_NOW(a_voice_range, st == ST_MUL1, vidx < n_cl, "stepped a voice past the enabled count")
  `MAS_ASSERT_NOW(a_cdiv_den, st == ST_CDIV, cden != 4'd0, "mix divide by zero")
  `MAS_ASSERT_NEXT(a_done_pop, (st == ST_DONE) && res_ready, st == ST_IDLE, "result held after it was taken")
  `MAS_ASSERT_NOW(a_no_pop_busy, q_ready, st == ST_IDLE, "item taken while a tick is in flight")

endmodule

### src/multichannel_adsr_wave_synth.sv
// Top level of the ADSR wavetable synthesizer: APB register, input queue,
// voice engine and a two-entry result queue. Uses mas_pkg, mas_front, mas_back.
//
// Commands (play, envelope, stop, stop all) pass through the input queue and
// engine. A sample tick walks the enabled voices one at a time: an active
// voice passes the voice, first and second multiply states, plus a divide
// when its envelope is ramping (a load, one quotient bit a cycle, a level
// write); then the mix is divided by the active count and scaled before the
// result is offered. Inactive voices are skipped in the voice state. Only
// ticks give a result.
module multichannel_adsr_wave_synth import mas_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           mode,
  input  logic [VOICE_W-1:0]   voice,
  input  logic [15:0]          phase_step,
  input  logic [15:0]          volume,
  input  logic [2:0]           waveform,
  input  logic [15:0]          duty,
  input  logic [TIME_BITS-1:0] attack_len,
  input  logic [TIME_BITS-1:0] decay_len,
  input  logic [15:0]          sustain_level,
  input  logic [TIME_BITS-1:0] release_len,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [15:0]   audio_out,
  output logic [7:0]           active_voices
);

  logic [3:0]  voices_enabled;
  logic        q_valid, q_ready;
  item_t       q_item;
  logic        res_valid, res_ready;
  logic [15:0] res_audio;
  logic [7:0]  res_active;
  logic [15:0] oq_audio  [2];
  logic [7:0]  oq_active [2];
  logic        owr, ord;
  logic [1:0]  ocnt;
  logic        do_w, do_r;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_VOICES) ? {28'd0, voices_enabled} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) voices_enabled <= VOICES_RST;
    else if (psel && penable && pwrite) voices_enabled <= pwdata[3:0];
  end

  mas_front u_front (
    .clk, .rst, .push, .full, .mode, .voice, .phase_step, .volume, .waveform,
    .duty, .attack_len, .decay_len, .sustain_level, .release_len,
    .q_valid, .q_item, .q_ready
  );

  mas_back u_back (
    .clk, .rst, .voices_en(voices_enabled), .q_valid, .q_item, .q_ready,
    .res_valid, .res_audio, .res_active, .res_ready
  );

  // result queue
  assign res_ready     = (ocnt != 2'd2);
  assign empty         = (ocnt == 2'd0);
  assign audio_out     = $signed(oq_audio[ord]);
  assign active_voices = oq_active[ord];
  assign do_w          = res_valid && res_ready;
  assign do_r          = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      owr  <= 1'b0;
      ord  <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (do_w) begin
        oq_audio[owr]  <= res_audio;
        oq_active[owr] <= res_active;
        owr            <= !owr;
      end
      if (do_r) ord <= !ord;
      ocnt <= ocnt + 2'(do_w) - 2'(do_r);
    end
  end

endmodule
